>>> design/bblwb_pkg.sv
// shared types and constants of the bayer black level and white balance block
`default_nettype none
package bblwb_pkg;

  localparam int unsigned PIX_W          = 16;
  localparam int unsigned GAIN_W         = 20;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned CFG_DATA_W     = 20;
  localparam int unsigned GAIN_FRAC      = 12;
  localparam int unsigned PROD_W         = PIX_W + GAIN_W;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(4096);
  localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(2048);

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_GR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_RED = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_BLU = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_GB  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GR   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_RED  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_BLU  = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_GB   = CFG_IDX_W'(7);

  // bayer channel, bit 1 is row parity and bit 0 column parity
  typedef enum logic [1:0] {
    CH_GR  = 2'd0,
    CH_RED = 2'd1,
    CH_BLU = 2'd2,
    CH_GB  = 2'd3
  } chan_e;

  typedef struct packed {
    chan_e            ch;
    logic [PIX_W-1:0] pix;
  } item_t;

endpackage
`default_nettype wire

>>> design/bblwb_if.sv
// stream and configuration channel interfaces
`default_nettype none
interface bblwb_pix_if;
  import bblwb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             frame_start;
  logic             line_start;
  modport source (output valid, output pixel_in, output frame_start, output line_start,
                  input ready);
  modport sink (input valid, input pixel_in, input frame_start, input line_start,
                output ready);
endinterface

interface bblwb_res_if;
  import bblwb_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             clipped;
  modport source (output valid, output pixel_out, output clipped, input ready);
  modport sink (input valid, input pixel_out, input clipped, output ready);
endinterface

interface bblwb_cfg_if;
  import bblwb_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/bblwb_front.sv
// front end: accepts pixels, tracks bayer parity and tags each pixel with its channel
`default_nettype none
module bblwb_front #(
  parameter int unsigned PIXEL_BITS = bblwb_pkg::PIXEL_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  bblwb_pix_if.sink            pix_i,
  output bblwb_pkg::item_t     item_o,
  output logic                 item_valid_o,
  input  wire logic            item_ready_i
);
  import bblwb_pkg::*;

  localparam logic [PIX_W-1:0] PixMask = PIX_W'((32'd1 << PIXEL_BITS) - 32'd1);

  logic  row_odd_q, row_odd_d;
  logic  col_odd_q, col_odd_d;
  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;
  logic  row, col;

  assign pix_i.ready = !valid_q || item_ready_i;
  assign take        = pix_i.valid && pix_i.ready;

  always_comb begin
    if (pix_i.frame_start) begin
      row = 1'b0;
    end else if (pix_i.line_start) begin
      row = !row_odd_q;
    end else begin
      row = row_odd_q;
    end
    col = (pix_i.frame_start || pix_i.line_start) ? 1'b0 : col_odd_q;
  end

  always_comb begin
    row_odd_d = row_odd_q;
    col_odd_d = col_odd_q;
    valid_d   = valid_q && !item_ready_i;
    if (take) begin
      row_odd_d = row;
      col_odd_d = !col;
      valid_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_odd_q <= 1'b0;
      col_odd_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      row_odd_q <= row_odd_d;
      col_odd_q <= col_odd_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.ch  <= chan_e'({row, col});
      item_q.pix <= pix_i.pixel_in & PixMask;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule
`default_nettype wire

>>> design/bblwb_fifo.sv
// two-entry queue between the front end and the correction pipeline
`default_nettype none
module bblwb_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bblwb_pkg::item_t  wr_item_i,
  input  wire logic              wr_valid_i,
  output logic                   wr_ready_o,
  output bblwb_pkg::item_t       rd_item_o,
  output logic                   rd_valid_o,
  input  wire logic              rd_ready_i
);
  import bblwb_pkg::*;

  item_t       mem [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule
`default_nettype wire

>>> design/bblwb_back.sv
// back end: register file, black subtract, gain multiply, round and saturate
`default_nettype none
module bblwb_back #(
  parameter int unsigned PIXEL_BITS = bblwb_pkg::PIXEL_BITS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bblwb_cfg_if.sink              cfg_i,
  input  wire bblwb_pkg::item_t  item_i,
  input  wire logic              item_valid_i,
  output logic                   item_ready_o,
  bblwb_res_if.source            res_o
);
  import bblwb_pkg::*;

  localparam int unsigned RES_W = PROD_W + 1 - GAIN_FRAC;
  localparam logic [RES_W-1:0] PixMax = RES_W'((64'd1 << PIXEL_BITS) - 64'd1);

  logic [PIX_W-1:0]  black_q [4];
  logic [GAIN_W-1:0] gain_q  [4];

  logic              v1_q, v2_q, v3_q;
  logic              adv1, adv2, adv3;
  logic [PIX_W-1:0]  diff_q;
  logic [GAIN_W-1:0] gsel_q;
  logic [PROD_W-1:0] prod_q;
  logic [PIX_W-1:0]  pix_out_q;
  logic              clip_q;

  logic [PIX_W-1:0]  black_sel;
  logic [PROD_W:0]   rounded;
  logic [RES_W-1:0]  res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        black_q[i] <= '0;
        gain_q[i]  <= GAIN_UNITY;
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_BLACK_GR:  black_q[CH_GR]  <= cfg_i.data[PIX_W-1:0];
        REG_BLACK_RED: black_q[CH_RED] <= cfg_i.data[PIX_W-1:0];
        REG_BLACK_BLU: black_q[CH_BLU] <= cfg_i.data[PIX_W-1:0];
        REG_BLACK_GB:  black_q[CH_GB]  <= cfg_i.data[PIX_W-1:0];
        REG_GAIN_GR:   gain_q[CH_GR]   <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_RED:  gain_q[CH_RED]  <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_BLU:  gain_q[CH_BLU]  <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_GB:   gain_q[CH_GB]   <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // each stage moves when it is empty or the next one moves
  assign adv3         = !v3_q || res_o.ready;
  assign adv2         = !v2_q || adv3;
  assign adv1         = !v1_q || adv2;
  assign item_ready_o = adv1;

  assign black_sel = black_q[item_i.ch];
  assign rounded   = {1'b0, prod_q} + ROUND_HALF;
  assign res       = rounded[PROD_W:GAIN_FRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= item_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && item_valid_i) begin
      diff_q <= (item_i.pix > black_sel) ? item_i.pix - black_sel : '0;
      gsel_q <= gain_q[item_i.ch];
    end
    if (adv2 && v1_q) begin
      prod_q <= PROD_W'(diff_q) * PROD_W'(gsel_q);
    end
    if (adv3 && v2_q) begin
      if (res > PixMax) begin
        pix_out_q <= PixMax[PIX_W-1:0];
        clip_q    <= 1'b1;
      end else begin
        pix_out_q <= res[PIX_W-1:0];
        clip_q    <= 1'b0;
      end
    end
  end

  assign res_o.valid     = v3_q;
  assign res_o.pixel_out = pix_out_q;
  assign res_o.clipped   = clip_q;

endmodule
`default_nettype wire

>>> design/bayer_black_level_white_balance.sv
// top level: bayer black level subtraction and white balance gain, one pixel per clock while res_o is ready
// an input transfer passes the front register, the queue and the three back stages before its result is on res_o
// throughput: one pixel per cycle while res_o is ready, set by the fully pipelined multiply stage
// the front register, a two-entry queue and three back stages each stall on their own
// reset: parity goes to even row and column, black levels to 0, gains to 4096,
// and all stages and the queue empty
`default_nettype none
module bayer_black_level_white_balance #(
  parameter int unsigned PIXEL_BITS = bblwb_pkg::PIXEL_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bblwb_pix_if.sink   pix_i,
  bblwb_cfg_if.sink   cfg_i,
  bblwb_res_if.source res_o
);
  import bblwb_pkg::*;

  item_t front_item;
  logic  front_valid;
  logic  front_ready;
  item_t back_item;
  logic  back_valid;
  logic  back_ready;

  bblwb_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  bblwb_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_item_i  (front_item),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_item_o  (back_item),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  bblwb_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .item_i       (back_item),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .res_o        (res_o)
  );

endmodule
`default_nettype wire
